// ----- rtl/mfd_pkg.sv -----
// Shared types and constants for the marker frame deframer with sum check.
package mfd_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MIN     = CNT_W'(5);
    localparam logic [8:0]        HDR_BYTES   = 9'd5;
    localparam logic [ADDR_W-1:0] PAY_BASE    = ADDR_W'(3);

    localparam logic [7:0] START_RESET = 8'hAA;
    localparam logic [7:0] END_RESET   = 8'h55;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SUM = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    typedef struct packed {
        logic              store;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              close;
        logic [1:0]        status;
        logic [7:0]        cmd;
        logic [7:0]        len;
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD,
        BK_OUT,
        BK_STAT
    } t_back_state;

endpackage

// ----- rtl/mfd_front.sv -----
// Front part: frame tracking, running checksum and classification of received bytes.
module mfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output mfd_pkg::t_op      o_op,
    input  logic              i_full
);
    import mfd_pkg::*;

    logic [7:0]       r_start;
    logic [7:0]       r_end;
    logic             r_in_frame;
    logic             n_in_frame;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_sum;
    logic [7:0]       n_sum;
    logic [7:0]       r_prev1;
    logic [7:0]       n_prev1;
    logic [7:0]       r_prev2;
    logic [7:0]       n_prev2;
    logic [7:0]       r_cmd;
    logic [7:0]       n_cmd;
    logic [7:0]       r_len;
    logic [7:0]       n_len;
    logic             accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_sum      = r_sum;
        n_prev1    = r_prev1;
        n_prev2    = r_prev2;
        n_cmd      = r_cmd;
        n_len      = r_len;
        o_push     = 1'b0;
        o_op       = '0;
        if (accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == r_start) begin
                    n_in_frame  = 1'b1;
                    n_count     = CNT_W'(1);
                    n_sum       = 8'd0;
                    n_prev1     = i_rx_byte;
                    o_push      = 1'b1;
                    o_op.store  = 1'b1;
                    o_op.addr   = '0;
                    o_op.data   = i_rx_byte;
                end
            end else begin
                o_push = 1'b1;
                if (r_count < CNT_FULL) begin
                    o_op.store = 1'b1;
                    o_op.addr  = r_count[ADDR_W-1:0];
                    o_op.data  = i_rx_byte;
                    n_count    = r_count + CNT_W'(1);
                    // The length byte is not part of the checksum.
                    if (r_count >= CNT_W'(3) && r_count != CNT_W'(4)) begin
                        n_sum = r_sum + r_prev2;
                    end
                    n_prev2 = r_prev1;
                    n_prev1 = i_rx_byte;
                    if (r_count == CNT_W'(1)) begin
                        n_cmd = i_rx_byte;
                    end
                    if (r_count == CNT_W'(2)) begin
                        n_len = i_rx_byte;
                    end
                end
                if (i_rx_byte == r_end && n_count >= CNT_MIN) begin
                    o_op.close = 1'b1;
                    o_op.cmd   = r_cmd;
                    o_op.len   = r_len;
                    if (9'(n_count) != (9'(r_len) + HDR_BYTES)) begin
                        o_op.status = ST_LEN;
                    end else if (n_sum != n_prev2) begin
                        o_op.status = ST_SUM;
                    end else begin
                        o_op.status = ST_OK;
                    end
                    n_in_frame = 1'b0;
                    n_count    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= START_RESET;
            r_end      <= END_RESET;
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START) begin
                    r_start <= i_cfg_data;
                end else begin
                    r_end <= i_cfg_data;
                end
            end
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_prev1 <= n_prev1;
        r_prev2 <= n_prev2;
        r_cmd   <= n_cmd;
        r_len   <= n_len;
    end

endmodule

// ----- rtl/mfd_queue.sv -----
// Short queue of classified operations between the front and back parts.
module mfd_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mfd_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output mfd_pkg::t_op o_op,
    output logic         o_empty
);
    import mfd_pkg::*;

    t_op                r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_fill;

    assign o_full  = (r_fill == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ----- rtl/mfd_back.sv -----
// Back part: frame buffer memory, payload replay and the output register.
module mfd_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  mfd_pkg::t_op i_op,
    input  logic         i_empty,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_item_kind,
    output logic [7:0]   o_command_id,
    output logic [7:0]   o_declared_length,
    output logic [1:0]   o_frame_status,
    output logic [7:0]   o_payload_byte,
    output logic         o_last_item
);
    import mfd_pkg::*;

    logic [7:0]        r_mem [BUFFER_BYTES];
    logic [7:0]        r_rd_data;
    t_back_state       r_state;
    t_back_state       n_state;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;
    logic [7:0]        r_cmd;
    logic [7:0]        r_len;
    logic [1:0]        r_status;
    logic              latch_close;
    logic              rd_en;
    logic              load_pay;
    logic              load_stat;
    logic              out_free;
    logic              r_out_valid;
    logic              r_kind;
    logic [7:0]        r_out_cmd;
    logic [7:0]        r_out_len;
    logic [1:0]        r_out_status;
    logic [7:0]        r_out_pay;
    logic              r_out_last;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        latch_close = 1'b0;
        rd_en       = 1'b0;
        load_pay    = 1'b0;
        load_stat   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_op.close) begin
                        latch_close = 1'b1;
                        n_idx       = '0;
                        if (i_op.status == ST_OK && i_op.len != 8'd0) begin
                            n_state = BK_RD;
                        end else begin
                            n_state = BK_STAT;
                        end
                    end
                end
            end
            BK_RD: begin
                rd_en   = 1'b1;
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (out_free) begin
                    load_pay = 1'b1;
                    if ((8'(r_idx) + 8'd1) == r_len) begin
                        n_state = BK_STAT;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = BK_RD;
                    end
                end
            end
            BK_STAT: begin
                if (out_free) begin
                    load_stat = 1'b1;
                    n_state   = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.store) begin
            r_mem[i_op.addr] <= i_op.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[PAY_BASE + r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_pay || load_stat) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (latch_close) begin
            r_cmd    <= i_op.cmd;
            r_len    <= i_op.len;
            r_status <= i_op.status;
        end
        if (load_pay) begin
            r_kind       <= KIND_PAYLOAD;
            r_out_cmd    <= r_cmd;
            r_out_len    <= r_len;
            r_out_status <= ST_OK;
            r_out_pay    <= r_rd_data;
            r_out_last   <= 1'b0;
        end else if (load_stat) begin
            r_kind       <= KIND_STATUS;
            r_out_cmd    <= r_cmd;
            r_out_len    <= r_len;
            r_out_status <= r_status;
            r_out_pay    <= 8'd0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_item_kind       = r_kind;
    assign o_command_id      = r_out_cmd;
    assign o_declared_length = r_out_len;
    assign o_frame_status    = r_out_status;
    assign o_payload_byte    = r_out_pay;
    assign o_last_item       = r_out_last;

endmodule

// ----- rtl/marker_frame_deframer_with_sum_check_unit.sv -----
// Top level of the marker frame deframer with additive sum check.
// Received bytes are taken one per cycle while the four-entry operation queue has room; the
// front part tracks the frame and its running sum, so the frame verdict is known as the end
// marker arrives. The back part writes each queued byte into the 64-byte buffer while idle, and
// for a good frame it replays the payload from that buffer one byte at a time (registered
// memory read in BK_RD, then the output register in BK_OUT, which waits while the output is
// stalled), followed by the status item for every frame. Input bytes are stalled only when the
// queue fills behind that replay.
module marker_frame_deframer_with_sum_check_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_item_kind,
    output logic [7:0] o_command_id,
    output logic [7:0] o_declared_length,
    output logic [1:0] o_frame_status,
    output logic [7:0] o_payload_byte,
    output logic       o_last_item
);
    import mfd_pkg::*;

    t_op  push_op;
    t_op  head_op;
    logic push;
    logic full;
    logic pop;
    logic empty;

    mfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_op       (push_op),
        .i_full     (full)
    );

    mfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_empty (empty)
    );

    mfd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (head_op),
        .i_empty           (empty),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_item_kind       (o_item_kind),
        .o_command_id      (o_command_id),
        .o_declared_length (o_declared_length),
        .o_frame_status    (o_frame_status),
        .o_payload_byte    (o_payload_byte),
        .o_last_item       (o_last_item)
    );

endmodule

// ----- tb/frame_result_checker.sv -----
// Output checker for the marker frame deframer: predicts items and compares each transfer.
module frame_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_item_kind,
    input  logic [7:0] i_command_id,
    input  logic [7:0] i_declared_length,
    input  logic [1:0] i_frame_status,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last_item,
    output int         o_fail_count,
    output int         o_pending
);
    import mfd_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [1:0] status;
        logic [7:0] pay;
        logic       last;
    } frame_item_t;

    logic [7:0]  open_marker;
    logic [7:0]  close_marker;
    logic [7:0]  frame_buf [BUFFER_BYTES];
    int          held;
    bit          framing;
    frame_item_t awaited_items [$];

    function automatic void add_item(logic kind, logic [7:0] cmd, logic [7:0] len,
                                     logic [1:0] status, logic [7:0] pay);
        frame_item_t it;
        it.kind   = kind;
        it.cmd    = cmd;
        it.len    = len;
        it.status = status;
        it.pay    = pay;
        it.last   = (kind == KIND_STATUS);
        awaited_items.push_back(it);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] sum;
        logic [1:0] verdict;
        if (!framing) begin
            if (b == open_marker) begin
                frame_buf[0] = b;
                held         = 1;
                framing      = 1'b1;
            end
        end else begin
            if (held < BUFFER_BYTES) begin
                frame_buf[held] = b;
                held++;
            end
            if (b == close_marker && held >= 5) begin
                cmd = frame_buf[1];
                len = frame_buf[2];
                sum = cmd;
                if (held != int'(len) + 5) begin
                    verdict = ST_LEN;
                end else begin
                    for (int i = 0; i < len; i++) sum += frame_buf[3 + i];
                    verdict = (sum == frame_buf[held - 2]) ? ST_OK : ST_SUM;
                end
                if (verdict == ST_OK) begin
                    for (int i = 0; i < len; i++)
                        add_item(KIND_PAYLOAD, cmd, len, ST_OK, frame_buf[3 + i]);
                end
                add_item(KIND_STATUS, cmd, len, verdict, 8'h00);
                framing = 1'b0;
                held    = 0;
            end
        end
    endfunction

    function automatic int field_bad(string name, logic [7:0] want, logic [7:0] got);
        field_bad = 0;
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            field_bad = 1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        frame_item_t want;
        int          bad;
        if (!i_rst_n) begin
            open_marker  = START_RESET;
            close_marker = END_RESET;
            held         = 0;
            framing      = 1'b0;
            awaited_items.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START) begin
                    open_marker = i_cfg_data;
                end else begin
                    close_marker = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) take_byte(i_rx_byte);
            if (i_out_valid && !i_out_stall) begin
                if (awaited_items.size() == 0) begin
                    $display("%0t: item expected none actual kind %0h cmd %0h len %0h",
                             $time, i_item_kind, i_command_id, i_declared_length);
                    o_fail_count++;
                end else begin
                    want = awaited_items.pop_front();
                    bad  = 0;
                    bad += field_bad("item_kind", 8'(want.kind), 8'(i_item_kind));
                    bad += field_bad("command_id", want.cmd, i_command_id);
                    bad += field_bad("declared_length", want.len, i_declared_length);
                    bad += field_bad("frame_status", 8'(want.status), 8'(i_frame_status));
                    bad += field_bad("payload_byte", want.pay, i_payload_byte);
                    bad += field_bad("last_item", 8'(want.last), 8'(i_last_item));
                    if (bad != 0) o_fail_count++;
                end
            end
        end
        o_pending = awaited_items.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the deframer testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    import mfd_pkg::*;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_LEN,
        FR_EARLY_END,
        FR_OVERFLOW
    } frame_kind_t;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 160;
    localparam int SETTLE_CYCLES = 24;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_item_kind;
    logic [7:0] o_command_id;
    logic [7:0] o_declared_length;
    logic [1:0] o_frame_status;
    logic [7:0] o_payload_byte;
    logic       o_last_item;

    logic [7:0] start_val = START_RESET;
    logic [7:0] end_val   = END_RESET;
    bit         idle_allowed;
    bit         tx_idle_on;
    bit         rx_idle_on;
    bit         rx_hold_req;
    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    int         frame_bytes;

    marker_frame_deframer_with_sum_check_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_item_kind       (o_item_kind),
        .o_command_id      (o_command_id),
        .o_declared_length (o_declared_length),
        .o_frame_status    (o_frame_status),
        .o_payload_byte    (o_payload_byte),
        .o_last_item       (o_last_item)
    );

    frame_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_item_kind       (o_item_kind),
        .i_command_id      (o_command_id),
        .i_declared_length (o_declared_length),
        .i_frame_status    (o_frame_status),
        .i_payload_byte    (o_payload_byte),
        .i_last_item       (o_last_item),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input frame_kind_t kind, input int n_pay);
        logic [7:0] pay [$];
        logic [7:0] seq [$];
        logic [7:0] cmd;
        logic [7:0] len_field;
        logic [7:0] sum;
        logic [7:0] chk;
        logic [7:0] b;
        cmd = 8'($urandom_range(0, 255));
        sum = cmd;
        for (int i = 0; i < n_pay; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == end_val);
            pay.push_back(b);
            sum += b;
        end
        // Keep the checksum byte from closing the frame one byte early.
        if (n_pay > 0 && sum == end_val) begin
            pay[0] = pay[0] + 8'd1;
            sum    = sum + 8'd1;
            if (pay[0] == end_val) begin
                pay[0] = pay[0] + 8'd1;
                sum    = sum + 8'd1;
            end
        end
        chk       = sum;
        len_field = 8'(n_pay);
        if (kind == FR_BAD_SUM) begin
            chk = sum ^ (8'h01 << $urandom_range(0, 7));
            if (chk == end_val) chk = ~sum;
        end
        if (kind == FR_BAD_LEN) begin
            len_field = 8'($urandom_range(0, 255));
            if (len_field == n_pay) len_field = len_field ^ 8'h01;
        end
        seq.push_back(start_val);
        if (kind == FR_EARLY_END) seq.push_back(end_val);
        seq.push_back(cmd);
        seq.push_back(len_field);
        foreach (pay[i]) seq.push_back(pay[i]);
        seq.push_back(chk);
        if (kind == FR_OVERFLOW) begin
            repeat ($urandom_range(1, 6)) begin
                do b = 8'($urandom_range(0, 255)); while (b == end_val);
                seq.push_back(b);
            end
        end
        seq.push_back(end_val);
        foreach (seq[i]) push_byte(seq[i]);
        frame_bytes += seq.size();
    endtask

    task automatic run_traffic(input int budget);
        int         roll;
        int         short_len;
        logic [7:0] b;
        frame_bytes = 0;
        while (frame_bytes < budget) begin
            roll       = $urandom_range(0, 99);
            short_len  = $urandom_range(0, 8);
            tx_idle_on = idle_allowed && $urandom_range(0, 4) != 0;
            if (roll < 60) begin
                send_frame(FR_GOOD, short_len);
            end else if (roll < 70) begin
                send_frame(FR_BAD_SUM, short_len);
            end else if (roll < 78) begin
                send_frame(FR_BAD_LEN, short_len);
            end else if (roll < 86) begin
                send_frame(FR_EARLY_END, short_len + 1);
            end else if (roll < 96) begin
                repeat ($urandom_range(1, 3)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == start_val);
                    push_byte(b);
                end
            end else if (roll < 98) begin
                send_frame(FR_OVERFLOW, 59);
            end else begin
                send_frame(FR_GOOD, $urandom_range(40, 59));
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START;
        i_cfg_data <= s;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_END;
        i_cfg_data <= e;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        start_val = s;
        end_val   = e;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_START;
        i_cfg_data   = 8'h00;
        i_in_valid   = 1'b0;
        i_rx_byte    = 8'h00;
        idle_allowed = 1'b1;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        rx_hold_req  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle noise, a minimal frame, a start marker carried as payload, a bad
        // checksum, and an end marker that arrives before five bytes are held.
        push_byte(8'h00); push_byte(8'hFF);
        push_byte(START_RESET); push_byte(8'hFF); push_byte(8'h00);
        push_byte(8'hFF); push_byte(END_RESET);
        push_byte(START_RESET); push_byte(8'h00); push_byte(8'h01);
        push_byte(START_RESET); push_byte(START_RESET); push_byte(END_RESET);
        push_byte(START_RESET); push_byte(8'h12); push_byte(8'h00);
        push_byte(8'h13); push_byte(END_RESET);
        push_byte(START_RESET); push_byte(END_RESET); push_byte(8'h01);
        push_byte(8'h00); push_byte(END_RESET);
        run_traffic(40);

        settle();
        set_markers(8'h00, 8'hFF);
        run_traffic(30);

        settle();
        set_markers(8'hFF, 8'h00);
        rx_hold_req = 1'b1;
        tx_idle_on  = 1'b0;
        send_frame(FR_GOOD, 50);
        send_frame(FR_GOOD, 12);
        run_traffic(25);

        settle();
        set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_traffic(30);

        settle();
        set_markers(8'h7E, 8'h7E);
        idle_allowed = 1'b0;
        rx_idle_on   = 1'b0;
        run_traffic(30);

        settle();
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
